/* rtl/core/pht_pkg.sv */
// shared types and constants for the position hypothesis table
package pht_pkg;
	localparam logic [4:0] CERT_MAX  = 5'd20;
	localparam logic [4:0] CERT_NEW  = 5'd10;
	localparam logic [4:0] CERT_KEEP = 5'd7;
	localparam logic [15:0] RADIUS_RESET = 16'd500;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [15:0]        conf;
		logic [4:0]         cert;
		logic               dirty;
	} entry_t;

	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [6:0]  den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] root;
	} div_rsp_t;
endpackage

/* rtl/core/pht_near.sv */
// shared distance test: squared distance against squared radius
module pht_near (
	input  logic signed [15:0] hx,
	input  logic signed [15:0] hy,
	input  logic signed [15:0] ox,
	input  logic signed [15:0] oy,
	input  logic [31:0]        r2,
	output logic               near
);
	logic signed [16:0] dx, dy;
	logic [33:0] d2;
	always_comb begin
		dx = 17'(hx) - 17'(ox);
		dy = 17'(hy) - 17'(oy);
		d2 = 34'(unsigned'(34'(dx * dx))) + 34'(unsigned'(34'(dy * dy)));
		near = d2 < {2'b00, r2};
	end
endmodule

/* rtl/core/pht_divsqrt.sv */
// iterative divide of a 32 bit value by a count, then bit-pair square root
module pht_divsqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  pht_pkg::div_req_t req,
	output pht_pkg::div_rsp_t rsp
);
	typedef enum logic [1:0] {IDLE, DIV, SQRT} st_t;
	st_t st_q;
	logic [31:0] quo_q;
	logic [6:0]  rem_q;
	logic [6:0]  den_q;
	logic [31:0] val_q;
	logic [17:0] res_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [7:0]  trial;
	logic        q_bit;
	logic [31:0] quo_nxt;
	logic [33:0] acc_q;
	logic [33:0] sq_trial;
	always_comb begin
		trial = {rem_q, quo_q[31]};
		q_bit = trial >= {1'b0, den_q};
		quo_nxt = {quo_q[30:0], q_bit};
		sq_trial = {acc_q[31:0], val_q[31:30]} - {14'd0, res_q, 2'b01};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				IDLE: begin
					if (req.start) begin
						quo_q <= req.num;
						den_q <= req.den;
						rem_q <= '0;
						cnt_q <= '0;
						st_q <= DIV;
					end
				end
				DIV: begin
					if (q_bit)
						rem_q <= 7'(trial - {1'b0, den_q});
					else
						rem_q <= trial[6:0];
					quo_q <= quo_nxt;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						// quotient feeds the root, two bits a step from the top
						val_q <= quo_nxt;
						st_q <= SQRT;
						cnt_q <= '0;
						acc_q <= '0;
						res_q <= '0;
					end
				end
				SQRT: begin
					if (!sq_trial[33]) begin
						acc_q <= sq_trial;
						res_q <= {res_q[16:0], 1'b1};
					end else begin
						acc_q <= {acc_q[31:0], val_q[31:30]};
						res_q <= {res_q[16:0], 1'b0};
					end
					val_q <= {val_q[29:0], 2'b00};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						st_q <= IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end
	assign rsp = {done_q, res_q[15:0]};
endmodule

/* rtl/core/position_hypothesis_table.sv */
// top level: hypothesis table with a sequencer over one shared distance unit
// request paths: a valid observation runs match, append, best, prune and select; an invalid
// observation runs prune and select; a decay runs decay and select, then divide and root when a best is reported
// throughput: one request at a time, tready low while a request is worked on; the next
// request is taken only after the previous result has been accepted on the output
// reset: empty table, match radius 500; table contents are not cleared
module position_hypothesis_table #(
	parameter int MAX_HYPOTHESES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// obs_valid, obs_x, obs_y, obs_z, obs_confidence, zero fill
	input  logic [71:0] s_tdata,
	// func
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// best_valid, best_x, best_y, best_z, best_confidence, best_slot,
	// best_certainty, entry_count, overflow
	output logic [79:0] m_tdata
);
	localparam int IW = (MAX_HYPOTHESES > 1) ? $clog2(MAX_HYPOTHESES) : 1;
	localparam int CW = $clog2(MAX_HYPOTHESES + 1);

	typedef enum logic [3:0] {
		IDLE, MATCH, APPEND, BEST, PRUNE, DECAY, SEL, SCALE, WAITD, OUT
	} st_t;

	st_t st_q;
	pht_pkg::entry_t mem_q [MAX_HYPOTHESES];
	logic [31:0] r2_q;
	logic        func_q, valid_q;
	logic signed [15:0] ox_q, oy_q, oz_q;
	logic [15:0] oc_q;
	logic [CW-1:0] cnt_q, i_q, w_q;
	logic [IW-1:0] best_q;
	logic [4:0]  bcert_q;
	logic        found_q, ovf_q;
	logic [79:0] out_q;
	logic        near;
	logic        keep;
	pht_pkg::entry_t cur;
	pht_pkg::entry_t wr_entry;
	logic            wr_en;
	logic [IW-1:0]   wr_idx;
	pht_pkg::div_req_t dreq;
	pht_pkg::div_rsp_t drsp;
	logic [31:0] conf2_s1;

	assign cur = mem_q[i_q[IW-1:0]];
	assign cfg_ready = 1'b1;
	assign s_tready = (st_q == IDLE);
	assign m_tvalid = (st_q == OUT);
	assign m_tdata = out_q;

	pht_near u_near (
		.hx(cur.x), .hy(cur.y), .ox(ox_q), .oy(oy_q), .r2(r2_q), .near(near)
	);

	pht_divsqrt u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		dreq.start = (st_q == SCALE);
		dreq.num = conf2_s1;
		dreq.den = 7'(cnt_q);
	end

	// an entry survives pruning unless weak or a non-best duplicate of the observation
	assign keep = !(cur.cert < pht_pkg::CERT_KEEP ||
	                (valid_q && i_q[IW-1:0] != best_q && near));

	// one table write per cycle, chosen by the sequencer state
	always_comb begin
		wr_en = 1'b0;
		wr_idx = i_q[IW-1:0];
		wr_entry = cur;
		case (st_q)
			MATCH: begin
				if (i_q < cnt_q && near) begin
					wr_en = 1'b1;
					wr_entry.x = ox_q;
					wr_entry.y = oy_q;
					wr_entry.z = oz_q;
					wr_entry.conf = oc_q;
					wr_entry.dirty = 1'b0;
					if (cur.cert < pht_pkg::CERT_MAX)
						wr_entry.cert = cur.cert + 5'd1;
				end
			end
			APPEND: begin
				if (!found_q && cnt_q < CW'(MAX_HYPOTHESES)) begin
					wr_en = 1'b1;
					wr_idx = cnt_q[IW-1:0];
					wr_entry = '{ox_q, oy_q, oz_q, oc_q, pht_pkg::CERT_NEW, 1'b0};
				end
			end
			PRUNE: begin
				// survivors are compacted down to the write pointer
				if (i_q < cnt_q && keep) begin
					wr_en = 1'b1;
					wr_idx = w_q[IW-1:0];
					wr_entry.dirty = valid_q ? cur.dirty : 1'b1;
				end
			end
			DECAY: begin
				if (i_q < cnt_q) begin
					wr_en = 1'b1;
					wr_entry.dirty = 1'b1;
					if (cur.dirty && cur.cert != 5'd0)
						wr_entry.cert = cur.cert - 5'd1;
				end
			end
			default: ;
		endcase
	end

	// table storage, writes driven by the sequencer; also registers the best entry's squared confidence
	always_ff @(posedge clk) begin
		conf2_s1 <= 32'(mem_q[best_q].conf) * 32'(mem_q[best_q].conf);
		if (wr_en)
			mem_q[wr_idx] <= wr_entry;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			cnt_q <= '0;
			i_q <= '0;
			w_q <= '0;
			r2_q <= 32'(pht_pkg::RADIUS_RESET) * 32'(pht_pkg::RADIUS_RESET);
		end else begin
			if (cfg_valid) begin
				r2_q <= 32'(cfg_data) * 32'(cfg_data);
			end
			case (st_q)
				IDLE: begin
					if (s_tvalid) begin
						func_q <= s_tuser;
						valid_q <= s_tdata[0];
						ox_q <= s_tdata[16:1];
						oy_q <= s_tdata[32:17];
						oz_q <= s_tdata[48:33];
						oc_q <= s_tdata[64:49];
						i_q <= '0;
						w_q <= '0;
						found_q <= 1'b0;
						ovf_q <= 1'b0;
						if (s_tuser) st_q <= DECAY;
						else if (s_tdata[0]) st_q <= MATCH;
						else st_q <= PRUNE;
					end
				end
				MATCH: begin
					if (i_q < cnt_q) begin
						if (near) found_q <= 1'b1;
						i_q <= i_q + CW'(1);
					end else st_q <= APPEND;
				end
				APPEND: begin
					if (!found_q) begin
						if (cnt_q < CW'(MAX_HYPOTHESES)) cnt_q <= cnt_q + CW'(1);
						else ovf_q <= 1'b1;
					end
					i_q <= '0;
					best_q <= '0;
					bcert_q <= '0;
					st_q <= BEST;
				end
				BEST: begin
					if (i_q < cnt_q) begin
						if (i_q == '0 || cur.cert > bcert_q) begin
							best_q <= i_q[IW-1:0];
							bcert_q <= cur.cert;
						end
						i_q <= i_q + CW'(1);
					end else begin
						i_q <= '0;
						st_q <= PRUNE;
					end
				end
				PRUNE: begin
					if (i_q < cnt_q) begin
						if (keep)
							w_q <= w_q + CW'(1);
						i_q <= i_q + CW'(1);
					end else begin
						cnt_q <= w_q;
						i_q <= '0;
						best_q <= '0;
						bcert_q <= '0;
						st_q <= SEL;
					end
				end
				DECAY: begin
					if (i_q < cnt_q) i_q <= i_q + CW'(1);
					else begin
						i_q <= '0;
						best_q <= '0;
						bcert_q <= '0;
						st_q <= SEL;
					end
				end
				SEL: begin
					if (i_q < cnt_q) begin
						if (i_q == '0 || cur.cert > bcert_q) begin
							best_q <= i_q[IW-1:0];
							bcert_q <= cur.cert;
						end
						i_q <= i_q + CW'(1);
					end else if (func_q && cnt_q != '0 && bcert_q >= pht_pkg::CERT_KEEP) begin
						st_q <= SCALE;
					end else begin
						out_q <= {ovf_q, 5'(cnt_q), bcert_q, 4'(best_q), 16'd0,
						          16'd0, 16'd0, 16'd0, 1'b0};
						st_q <= OUT;
					end
				end
				SCALE: st_q <= WAITD;
				WAITD: begin
					if (drsp.done) begin
						out_q <= {1'b0, 5'(cnt_q), bcert_q, 4'(best_q), drsp.root,
						          mem_q[best_q].z, mem_q[best_q].y, mem_q[best_q].x, 1'b1};
						st_q <= OUT;
					end
				end
				OUT: if (m_tready) st_q <= IDLE;
				default: st_q <= IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(MAX_HYPOTHESES))
		else $error("count above depth");
	assert property (@(posedge clk) disable iff (!arst_n) s_tready |-> !m_tvalid)
		else $error("ready while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == PRUNE && i_q >= cnt_q) |=> cnt_q <= $past(cnt_q))
		else $error("prune grew table");
	assert property (@(posedge clk) disable iff (!arst_n) (st_q == PRUNE) |-> w_q <= i_q)
		else $error("write pointer ahead");
endmodule
